// ===== rtl/oirm_pkg.sv =====
// ----------------------------------------------------------------------------
// Object id range map package
// Shared widths, reset values and command codes.
// ----------------------------------------------------------------------------
package oirm_pkg;

  localparam int ID_W          = 32;
  localparam int CNT_W         = 11;
  localparam int MAP_WORDS_DEF = 1024;
  localparam int OUT_DATA_W    = 16;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1024);

  localparam logic CMD_TEST = 1'b0;
  localparam logic CMD_MARK = 1'b1;

endpackage

// ===== rtl/object_id_range_map_unit.sv =====
// ----------------------------------------------------------------------------
// Object id range map
// Sorted list of busy-range boundaries in one RAM, with test and mark commands.
// ----------------------------------------------------------------------------
// A test reads every word below the count through the single RAM port; a mark
// then walks the list a pair at a time and, when a pair is inserted or merged,
// moves every word above it one pair up or down through the same port.
// One item is in work at a time; the result register frees the input side.
// Reset (rst, synchronous) empties the map and sets map_limit to 1024; the RAM
// contents are not cleared, as only words below the count are ever read.
module object_id_range_map_unit
  import oirm_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ID_W-1:0]       s_axis_tdata,   // object_id
  input  logic                  s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // was_used, boundary_count, map_error, zero pad
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [CNT_W-1:0] LIM_CAP =
    CNT_W'((MAP_WORDS >= 2048) ? 2046 : (MAP_WORDS / 2) * 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TEST = 4'd1;
  localparam logic [3:0] S_WLO  = 4'd2;
  localparam logic [3:0] S_WHI  = 4'd3;
  localparam logic [3:0] S_WEV  = 4'd4;
  localparam logic [3:0] S_MRD  = 4'd5;
  localparam logic [3:0] S_MCHK = 4'd6;
  localparam logic [3:0] S_SDRD = 4'd7;
  localparam logic [3:0] S_SDWR = 4'd8;
  localparam logic [3:0] S_SURD = 4'd9;
  localparam logic [3:0] S_SUWR = 4'd10;
  localparam logic [3:0] S_SUI0 = 4'd11;
  localparam logic [3:0] S_END  = 4'd12;
  localparam logic [3:0] S_AP2  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]       state;
  logic [ID_W-1:0]  id;
  logic [ID_W-1:0]  nxt;
  logic             cmd;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] map_limit;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] rk;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] k;
  logic             pend;
  logic             par;
  logic             used;
  logic             err;
  logic [ID_W-1:0]  lo;
  logic [ID_W-1:0]  hi;

  logic [ID_W-1:0]  mem [MAP_WORDS];
  logic [ID_W-1:0]  rdata;
  logic [CNT_W-1:0] raddr;
  logic [CNT_W-1:0] waddr;
  logic [ID_W-1:0]  wdata;
  logic             we;

  logic in_rng, at_lo, at_hi, below, full, issue;
  logic [CNT_W:0] i_w, k_w, cnt_w;

  assign nxt   = id + ID_W'(1);
  assign i_w   = {1'b0, i};
  assign k_w   = {1'b0, k};
  assign cnt_w = {1'b0, cnt};

  always_comb begin
    lim = {map_limit[CNT_W-1:1], 1'b0};
    if (lim > LIM_CAP) begin
      lim = LIM_CAP;
    end
  end

  assign in_rng = (id >= lo) && (id < rdata);
  assign at_lo  = (nxt == lo);
  assign at_hi  = (id == rdata);
  assign below  = (id < lo);
  assign full   = (cnt >= lim);
  assign issue  = (rk < cnt);

  // RAM port control, decoded from the sequencer state.
  always_comb begin
    raddr = '0;
    waddr = i;
    wdata = id;
    we    = 1'b0;
    unique case (state)
      S_TEST: raddr = rk;
      S_WLO:  raddr = i;
      S_WHI:  raddr = i + CNT_W'(1);
      S_MRD:  raddr = i + CNT_W'(2);
      S_SDRD: raddr = k + CNT_W'(2);
      S_SURD: raddr = k - CNT_W'(1);
      S_WEV: begin
        if (!in_rng) begin
          if (at_lo) begin
            we = 1'b1;
          end else if (at_hi) begin
            we    = 1'b1;
            waddr = i + CNT_W'(1);
            wdata = rdata + ID_W'(1);
          end else if (below && full) begin
            we = 1'b1;
          end
        end
      end
      S_SDWR: begin
        we    = 1'b1;
        waddr = k;
        wdata = rdata;
      end
      S_SUWR: begin
        we    = 1'b1;
        waddr = k + CNT_W'(1);
        wdata = rdata;
      end
      S_SUI0: we = 1'b1;
      S_END: begin
        if (i < lim) begin
          we = 1'b1;
        end else if (i == lim && i != '0) begin
          we    = 1'b1;
          waddr = i - CNT_W'(1);
          wdata = nxt;
        end
      end
      S_AP2: begin
        we    = 1'b1;
        waddr = i + CNT_W'(1);
        wdata = nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(waddr)] <= wdata;
    end
    rdata <= mem[AW'(raddr)];
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      map_limit     <= LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (cfg_we) begin
        map_limit <= cfg_wdata;
      end
      // The result state sets the valid flag itself when it offers a result.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            id    <= s_axis_tdata;
            cmd   <= s_axis_tuser;
            rk    <= '0;
            par   <= 1'b0;
            pend  <= 1'b0;
            err   <= 1'b0;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          // Parity of the words at or below the id; one read issued per cycle.
          pend <= issue;
          if (issue) begin
            rk <= rk + CNT_W'(1);
          end
          if (pend) begin
            par <= par ^ (rdata <= id);
          end
          if (!issue && !pend) begin
            used <= par;
            i    <= '0;
            if (cmd == CMD_MARK && !par) begin
              state <= (cnt > CNT_W'(1)) ? S_WLO : S_END;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WLO: state <= S_WHI;
        S_WHI: begin
          lo    <= rdata;
          state <= S_WEV;
        end
        S_WEV: begin
          hi <= rdata;
          if (in_rng || at_lo) begin
            state <= S_DONE;
          end else if (at_hi) begin
            state <= (i_w + 12'd2 < cnt_w) ? S_MRD : S_DONE;
          end else if (below) begin
            k     <= cnt;
            state <= full ? S_DONE : S_SURD;
          end else begin
            i     <= i + CNT_W'(2);
            state <= (i_w + 12'd3 < cnt_w) ? S_WLO : S_END;
          end
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          // The raised end now touches the next start: close the gap.
          if (rdata == hi + ID_W'(1)) begin
            k     <= i + CNT_W'(1);
            state <= S_SDRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SDRD: state <= S_SDWR;
        S_SDWR: begin
          k <= k + CNT_W'(1);
          if (k_w + 12'd3 < cnt_w) begin
            state <= S_SDRD;
          end else begin
            cnt   <= cnt - CNT_W'(2);
            state <= S_DONE;
          end
        end
        S_SURD: state <= S_SUWR;
        S_SUWR: begin
          k     <= k - CNT_W'(1);
          state <= (k - CNT_W'(1) > i) ? S_SURD : S_SUI0;
        end
        S_SUI0: state <= S_AP2;
        S_END: begin
          if (i < lim) begin
            state <= S_AP2;
          end else begin
            err   <= !(i == lim && i != '0);
            state <= S_DONE;
          end
        end
        S_AP2: begin
          cnt   <= cnt + CNT_W'(2);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, err, cnt, used};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/oirm_checker.sv =====
// ----------------------------------------------------------------------------
// Object id range map checker
// Port-level properties of the range map, bound to the top level.
// ----------------------------------------------------------------------------
module oirm_checker
  import oirm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Boundaries always come in pairs, so the count is even.
  a_count_even: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[1])
    else $error("odd boundary count");

  // An error only arises on a mark of a free id.
  a_err_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[12]) |-> !m_axis_tdata[0])
    else $error("map error reported for a busy id");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind object_id_range_map_unit oirm_checker u_oirm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/object_id_range_map_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Object id range map testbench
// Drives test and mark commands through the stream ports, predicts each result
// from a local copy of the boundary list and compares field by field.
// ----------------------------------------------------------------------------
module object_id_range_map_unit_tb;
  import oirm_pkg::*;

  localparam int WORDS = 1024;

  typedef struct packed {
    logic             was_used;
    logic [CNT_W-1:0] count;
    logic             err;
  } map_result_t;

  class range_map_scoreboard;
    logic [ID_W-1:0]  bounds [WORDS];
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] limit;
    map_result_t      pending [$];
    int               errors;

    function void clear();
      count = 0;
      limit = LIMIT_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function logic busy(logic [ID_W-1:0] id);
      int n;
      n = 0;
      for (int k = 0; k < count; k++)
        if (bounds[k] <= id) n++;
      return n[0];
    endfunction

    // Returns 1 when the walk ends beyond the usable limit, or at a zero limit.
    function logic mark(logic [ID_W-1:0] id);
      int lim, i, cur;
      logic [ID_W-1:0] nxt, lo, hi;
      cur = count;
      lim = limit & 11'h7FE;
      if (lim > WORDS) lim = WORDS;
      nxt = id + 1;
      for (i = 0; i + 1 < cur; i += 2) begin
        lo = bounds[i];
        hi = bounds[i+1];
        if (id >= lo && id < hi) return 0;
        if (nxt == lo) begin
          bounds[i] = id;
          return 0;
        end
        if (id == hi) begin
          bounds[i+1] = hi + 1;
          if (i + 2 < cur && bounds[i+1] == bounds[i+2]) begin
            for (int k = i + 1; k + 2 < cur; k++) bounds[k] = bounds[k+2];
            count = cur - 2;
          end
          return 0;
        end
        if (id < lo) begin
          if (cur >= lim) begin
            bounds[i] = id;
            return 0;
          end
          for (int k = cur; k > i; k--)
            if (k + 1 < WORDS) bounds[k+1] = bounds[k-1];
          count = cur + 2;
          bounds[i] = id;
          bounds[i+1] = nxt;
          return 0;
        end
      end
      if (i < lim && i + 2 <= WORDS) begin
        bounds[i] = id;
        bounds[i+1] = nxt;
        count = cur + 2;
        return 0;
      end
      if (i == lim && i > 0) begin
        bounds[i-1] = nxt;
        return 0;
      end
      return 1;
    endfunction

    function void note_command(logic cmd, logic [ID_W-1:0] id);
      map_result_t r;
      r.was_used = busy(id);
      r.err = 0;
      if (cmd == CMD_MARK && !r.was_used) r.err = mark(id);
      r.count = count;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      map_result_t got, want;
      got.was_used = data[0];
      got.count = data[CNT_W:1];
      got.err = data[CNT_W+1];
      if (pending.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.was_used !== want.was_used) begin
        $display("%0t: was_used expected %0d actual %0d", $time, want.was_used, got.was_used);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: boundary_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.err !== want.err) begin
        $display("%0t: map_error expected %0d actual %0d", $time, want.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic                  clk, rst;
  logic                  s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [ID_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;

  range_map_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  logic [ID_W-1:0] id_base;

  object_id_range_map_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  // Output side: random back-pressure, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The valid flag stays up after a transfer; an idle gap or a drain drops it.
  task automatic send_command(logic cmd, logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= id;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(cmd, id);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_limit(logic [CNT_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = value;
  endtask

  // Ids clustered near a moving base so ranges grow, touch and merge.
  task automatic random_phase(int items, int idle, int stall);
    logic [ID_W-1:0] id;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < items; n++) begin
      case ($urandom_range(9))
        0: id = $urandom();
        1: id = 32'hFFFF_FFFF - $urandom_range(3);
        default: id = id_base + $urandom_range(60);
      endcase
      send_command(($urandom_range(3) != 0) ? CMD_MARK : CMD_TEST, id);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tuser = CMD_TEST;
    s_axis_tdata = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    m_axis_tready = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty map, extremes, extend up/down, merge, insert, wrap.
    send_command(CMD_TEST, 32'h0);
    send_command(CMD_MARK, 32'hFFFF_FFFF);
    send_command(CMD_TEST, 32'hFFFF_FFFF);
    send_command(CMD_MARK, 32'd10);
    send_command(CMD_MARK, 32'd11);
    send_command(CMD_MARK, 32'd9);
    send_command(CMD_MARK, 32'd10);
    send_command(CMD_MARK, 32'd5);
    send_command(CMD_MARK, 32'd7);
    send_command(CMD_MARK, 32'd6);
    send_command(CMD_MARK, 32'd0);
    send_command(CMD_TEST, 32'd8);
    send_command(CMD_MARK, 32'h8000_0000);
    send_command(CMD_MARK, 32'h5555_5555);
    send_command(CMD_MARK, 32'hAAAA_AAAA);
    send_command(CMD_TEST, 32'h7FFF_FFFF);

    // Full list at a tight limit: widening and walk-past-limit error.
    set_limit(11'd2);
    send_command(CMD_MARK, 32'd100);
    send_command(CMD_MARK, 32'd3);
    set_limit(11'd0);
    send_command(CMD_MARK, 32'd200);
    set_limit(11'd1);
    send_command(CMD_MARK, 32'd300);

    // Random part on the map left by the directed items, with small and large limits.
    set_limit(11'd6);
    id_base = 32'h1000;
    random_phase(60, 0, 0);
    set_limit(11'd7);
    random_phase(60, 82, 0);
    drain_results();  // sender waits for every result
    set_limit(11'd40);
    id_base = 32'h2000;
    random_phase(120, 0, 82);
    set_limit(11'd2047);
    id_base = 32'hFFFF_FFC0;
    random_phase(120, 34, 34);
    set_limit(11'd1024);
    id_base = 32'h4000;
    random_phase(120, 0, 0);
    set_limit(11'd3);
    random_phase(80, 34, 34);
    drain_results();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/oirm_pkg.sv
rtl/object_id_range_map_unit.sv
rtl/oirm_checker.sv
tb/object_id_range_map_unit_tb.sv
